@@ hdl/vps_pkg.sv @@
// Shared constants, types and helper functions for the Verlet particle block.
`timescale 1ns / 1ps
package vps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DAMP_BITS = 16;
    localparam logic [16:0] DAMP_FULL = 17'd65536;

    localparam logic [2:0] FUNC_FORCE  = 3'd0;
    localparam logic [2:0] FUNC_INTEG  = 3'd1;
    localparam logic [2:0] FUNC_GROUND = 3'd2;
    localparam logic [2:0] FUNC_SPHERE = 3'd3;
    localparam logic [2:0] FUNC_OFFSET = 3'd4;
    localparam logic [2:0] FUNC_SETPOS = 3'd5;

    localparam logic CFG_DAMPING = 1'b0;
    localparam logic CFG_PINNED  = 1'b1;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clamp_t;

    function automatic clamp_t clamp32(input logic signed [65:0] v);
        clamp_t r;
        r.sat = 1'b1;
        if (v > 66'sh0_7FFF_FFFF)
            r.val = 32'h7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r.val = 32'h8000_0000;
        else
        begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

@@ hdl/verlet_particle_step.sv @@
// Top level: one Verlet cloth particle with serial multiply, divide and square root.
//
//  channel | direction | signals
//  --------+-----------+---------------------------------------------
//  in      | sink      | in_valid, in_ready, func, vec_*, scalar
//  out     | source    | out_valid, out_ready, pos_*, grounded, saturated
//  cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Add force, offset, set position and ground check go from EXEC straight to DONE.
// Integrate runs two products per axis on the bit-serial multiplier (33 steps per product).
// Sphere check runs four squares, the root, then a product and a divide per axis.
// Reset clears the particle state and control registers at once (not the datapath or output data); no clearing pass.
// A finished result waits in the output register while the next transfer is taken.
`timescale 1ns / 1ps
module verlet_particle_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          func,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    input  logic signed [31:0]  scalar,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic                grounded,
    output logic                saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data
);
    import vps_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_EXEC  = 5'd1;
    localparam logic [4:0] ST_IVEL  = 5'd2;
    localparam logic [4:0] ST_IACC  = 5'd3;
    localparam logic [4:0] ST_ISUM  = 5'd4;
    localparam logic [4:0] ST_SSQ   = 5'd5;
    localparam logic [4:0] ST_SSQA  = 5'd6;
    localparam logic [4:0] ST_SRR   = 5'd7;
    localparam logic [4:0] ST_SRRC  = 5'd8;
    localparam logic [4:0] ST_SQ    = 5'd9;
    localparam logic [4:0] ST_SQD   = 5'd10;
    localparam logic [4:0] ST_SQF   = 5'd11;
    localparam logic [4:0] ST_MUL   = 5'd12;
    localparam logic [4:0] ST_DIV   = 5'd13;
    localparam logic [4:0] ST_ROOT  = 5'd14;
    localparam logic [4:0] ST_DONE  = 5'd15;

    logic [4:0]         state_reg, state_next, ret_reg, ret_next;
    logic [1:0]         comp_reg, comp_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] prev_next [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] acc_next [3];
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];
    logic               gnd_reg, gnd_next;
    logic               sat_reg, sat_next;
    logic [16:0]        damp_reg;
    logic               pin_reg;
    logic [2:0]         func_reg, func_next;
    logic signed [31:0] v_reg [3];
    logic signed [31:0] v_next [3];
    logic signed [31:0] sc_reg, sc_next;
    logic [63:0]        mul_a_reg, mul_a_next, mul_p_reg, mul_p_next;
    logic [32:0]        mul_b_reg, mul_b_next;
    logic               mul_neg_reg, mul_neg_next;
    logic signed [65:0] vel_reg, vel_next;
    logic [63:0]        s_reg, s_next;
    logic [63:0]        rt_x_reg, rt_x_next, rt_res_reg, rt_res_next, rt_bit_reg, rt_bit_next;
    logic [63:0]        dv_n_reg, dv_n_next;
    logic [32:0]        dv_rem_reg, dv_rem_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_pos_reg [3];
    logic signed [31:0] out_pos_next [3];
    logic               out_gnd_reg, out_gnd_next, out_sat_reg, out_sat_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign grounded  = out_gnd_reg;
    assign saturated = out_sat_reg;

    always_comb
    begin
        logic [16:0]        keep;
        logic signed [65:0] prod_s;
        logic signed [65:0] rnd;
        logic signed [65:0] tot;
        logic signed [32:0] dif;
        logic signed [33:0] lim;
        logic [33:0]        rem_sh;
        logic [63:0]        trial;
        logic [31:0]        root_val;
        logic               miss;
        clamp_t             cl;

        state_next = state_reg;
        ret_next   = ret_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        d_next     = d_reg;
        gnd_next   = gnd_reg;
        sat_next   = sat_reg;
        func_next  = func_reg;
        v_next     = v_reg;
        sc_next    = sc_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        mul_p_next = mul_p_reg;
        mul_neg_next = mul_neg_reg;
        vel_next   = vel_reg;
        s_next     = s_reg;
        rt_x_next  = rt_x_reg;
        rt_res_next = rt_res_reg;
        rt_bit_next = rt_bit_reg;
        dv_n_next  = dv_n_reg;
        dv_rem_next = dv_rem_reg;
        out_valid_next = out_valid_reg;
        out_pos_next = out_pos_reg;
        out_gnd_next = out_gnd_reg;
        out_sat_next = out_sat_reg;

        keep   = (damp_reg > DAMP_FULL) ? 17'd0 : 17'(DAMP_FULL - damp_reg);
        prod_s = mul_neg_reg ? -$signed({2'b00, mul_p_reg}) : $signed({2'b00, mul_p_reg});
        rnd    = '0;
        tot    = '0;
        dif    = '0;
        lim    = $signed({{2{sc_reg[31]}}, sc_reg}) + (34'sd1 <<< FRAC_BITS);
        rem_sh = {dv_rem_reg, dv_n_reg[63]};
        trial  = rt_res_reg + rt_bit_reg;
        root_val = rt_res_reg[31:0];
        miss   = 1'b0;
        cl     = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    v_next[0] = vec_x;
                    v_next[1] = vec_y;
                    v_next[2] = vec_z;
                    sc_next   = scalar;
                    sat_next  = 1'b0;
                    comp_next = 2'd0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (func_reg)
                    FUNC_FORCE:
                        for (int i = 0; i < 3; i++)
                        begin
                            cl = clamp32(66'(acc_reg[i]) + 66'(v_reg[i]));
                            acc_next[i] = cl.val;
                            if (cl.sat)
                                sat_next = 1'b1;
                        end
                    FUNC_INTEG:
                    begin
                        if (pin_reg || gnd_reg)
                            for (int i = 0; i < 3; i++)
                                acc_next[i] = '0;
                        else
                            state_next = ST_IVEL;
                    end
                    FUNC_GROUND:
                    begin
                        if (34'(pos_reg[2]) <= lim)
                        begin
                            gnd_next = 1'b1;
                            if (pos_reg[2] <= sc_reg)
                                pos_next[2] = sc_reg;
                        end
                        else
                            gnd_next = 1'b0;
                    end
                    FUNC_SPHERE:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            dif = 33'(pos_reg[i]) - 33'(v_reg[i]);
                            d_next[i] = dif;
                            if (dif >= 33'(sc_reg) || dif <= -33'(sc_reg))
                                miss = 1'b1;
                        end
                        if (sc_reg > 0 && !miss)
                        begin
                            s_next = '0;
                            state_next = ST_SSQ;
                        end
                    end
                    FUNC_OFFSET:
                        if (!pin_reg)
                            for (int i = 0; i < 3; i++)
                            begin
                                cl = clamp32(66'(pos_reg[i]) + 66'(v_reg[i]));
                                pos_next[i] = cl.val;
                                if (cl.sat)
                                    sat_next = 1'b1;
                            end
                    FUNC_SETPOS:
                        for (int i = 0; i < 3; i++)
                            pos_next[i] = v_reg[i];
                    default:
                    begin
                    end
                endcase
            end
            ST_IVEL:
            begin
                dif = 33'(pos_reg[comp_reg]) - 33'(prev_reg[comp_reg]);
                mul_a_next   = 64'(mag33(dif));
                mul_b_next   = 33'(keep);
                mul_neg_next = dif[32];
                mul_p_next   = '0;
                cnt_next     = 7'd33;
                ret_next     = ST_IACC;
                state_next   = ST_MUL;
            end
            ST_IACC:
            begin
                vel_next     = (prod_s + (66'sd1 <<< (DAMP_BITS - 1))) >>> DAMP_BITS;
                mul_a_next   = 64'(mag33(33'(acc_reg[comp_reg])));
                mul_b_next   = mag33(33'(sc_reg));
                mul_neg_next = acc_reg[comp_reg][31] ^ sc_reg[31];
                mul_p_next   = '0;
                cnt_next     = 7'd33;
                ret_next     = ST_ISUM;
                state_next   = ST_MUL;
            end
            ST_ISUM:
            begin
                rnd = (prod_s + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                tot = 66'(pos_reg[comp_reg]) + vel_reg + rnd;
                cl  = clamp32(tot);
                if (cl.sat)
                    sat_next = 1'b1;
                prev_next[comp_reg] = pos_reg[comp_reg];
                pos_next[comp_reg]  = cl.val;
                acc_next[comp_reg]  = '0;
                if (comp_reg == 2'd2)
                    state_next = ST_DONE;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_IVEL;
                end
            end
            ST_SSQ:
            begin
                mul_a_next   = 64'(mag33(d_reg[comp_reg]));
                mul_b_next   = mag33(d_reg[comp_reg]);
                mul_neg_next = 1'b0;
                mul_p_next   = '0;
                cnt_next     = 7'd33;
                ret_next     = ST_SSQA;
                state_next   = ST_MUL;
            end
            ST_SSQA:
            begin
                s_next = s_reg + mul_p_reg;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = ST_SRR;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_SSQ;
                end
            end
            ST_SRR:
            begin
                mul_a_next   = 64'(unsigned'(sc_reg));
                mul_b_next   = 33'(unsigned'(sc_reg));
                mul_neg_next = 1'b0;
                mul_p_next   = '0;
                cnt_next     = 7'd33;
                ret_next     = ST_SRRC;
                state_next   = ST_MUL;
            end
            ST_SRRC:
            begin
                if (s_reg == 64'd0 || s_reg >= mul_p_reg)
                    state_next = ST_DONE;
                else
                begin
                    rt_x_next   = s_reg;
                    rt_res_next = '0;
                    rt_bit_next = 64'd1 << 62;
                    cnt_next    = 7'd32;
                    ret_next    = ST_SQ;
                    state_next  = ST_ROOT;
                end
            end
            ST_SQ:
            begin
                mul_a_next   = 64'(mag33(d_reg[comp_reg]));
                mul_b_next   = 33'(unsigned'(sc_reg));
                mul_neg_next = 1'b0;
                mul_p_next   = '0;
                cnt_next     = 7'd33;
                ret_next     = ST_SQD;
                state_next   = ST_MUL;
            end
            ST_SQD:
            begin
                dv_n_next   = mul_p_reg + 64'(root_val >> 1);
                dv_rem_next = '0;
                cnt_next    = 7'd64;
                ret_next    = ST_SQF;
                state_next  = ST_DIV;
            end
            ST_SQF:
            begin
                rnd = d_reg[comp_reg][32] ? -$signed({2'b00, dv_n_reg})
                                          : $signed({2'b00, dv_n_reg});
                tot = 66'(v_reg[comp_reg]) + rnd;
                cl  = clamp32(tot);
                if (cl.sat)
                    sat_next = 1'b1;
                pos_next[comp_reg] = cl.val;
                if (comp_reg == 2'd2)
                    state_next = ST_DONE;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_SQ;
                end
            end
            ST_MUL:
            begin
                if (mul_b_reg[0])
                    mul_p_next = mul_p_reg + mul_a_reg;
                mul_a_next = mul_a_reg << 1;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = ret_reg;
            end
            ST_DIV:
            begin
                if (rem_sh >= 34'(root_val))
                begin
                    dv_rem_next = 33'(rem_sh - 34'(root_val));
                    dv_n_next   = {dv_n_reg[62:0], 1'b1};
                end
                else
                begin
                    dv_rem_next = rem_sh[32:0];
                    dv_n_next   = {dv_n_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = ret_reg;
            end
            ST_ROOT:
            begin
                if (rt_x_reg >= trial)
                begin
                    rt_x_next   = rt_x_reg - trial;
                    rt_res_next = (rt_res_reg >> 1) + rt_bit_reg;
                end
                else
                    rt_res_next = rt_res_reg >> 1;
                rt_bit_next = rt_bit_reg >> 2;
                cnt_next    = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    comp_next  = 2'd0;
                    state_next = ret_reg;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_gnd_next   = gnd_reg;
                    out_sat_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            comp_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            gnd_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            damp_reg      <= '0;
            pin_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                prev_reg[i] <= '0;
                acc_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            comp_reg      <= comp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            gnd_reg       <= gnd_next;
            sat_reg       <= sat_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            acc_reg       <= acc_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_DAMPING)
                    damp_reg <= cfg_data;
                else
                    pin_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        func_reg    <= func_next;
        v_reg       <= v_next;
        sc_reg      <= sc_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_p_reg   <= mul_p_next;
        mul_neg_reg <= mul_neg_next;
        vel_reg     <= vel_next;
        s_reg       <= s_next;
        rt_x_reg    <= rt_x_next;
        rt_res_reg  <= rt_res_next;
        rt_bit_reg  <= rt_bit_next;
        dv_n_reg    <= dv_n_next;
        dv_rem_reg  <= dv_rem_next;
        out_pos_reg <= out_pos_next;
        out_gnd_reg <= out_gnd_next;
        out_sat_reg <= out_sat_next;
    end

endmodule

@@ hdl/vps_checker.sv @@
// Port checker for the Verlet particle block, with its bind statement.
`timescale 1ns / 1ps
module vps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [2:0]          func,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [31:0]  pos_x,
    input logic signed [31:0]  pos_y,
    input logic signed [31:0]  pos_z,
    input logic                grounded,
    input logic                saturated
);
    import vps_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({pos_x, pos_y, pos_z, grounded, saturated}))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_setpos_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_SETPOS |=> ##1 !in_ready)
        else $error("set position finished too early");

endmodule

bind verlet_particle_step vps_checker u_vps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .grounded  (grounded),
    .saturated (saturated)
);
